### rtl/awb_pkg.sv
package awb_pkg;

  // default source image side; sets bank depth
  localparam int DEF_MAX_SIDE = 32;

  // front-to-back queue depth, power of two
  localparam int QUEUE_DEPTH = 4;

  // stream data width: 18 payload bits padded to whole bytes
  localparam int TDATA_W = 24;

  // APB-style port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] col;
    logic [4:0] row;
    logic [7:0] value;
  } item_t;

  // live configuration seen by the back end; side already clamped
  typedef struct packed {
    logic        [5:0]  side;
    logic signed [15:0] coef_xx;
    logic signed [15:0] coef_xy;
    logic signed [15:0] coef_yx;
    logic signed [15:0] coef_yy;
    logic signed [15:0] shift_x;
    logic signed [15:0] shift_y;
  } cfg_t;

endpackage

### rtl/awb_front.sv
module awb_front #(
  parameter int MAX_SIDE = awb_pkg::DEF_MAX_SIDE
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [awb_pkg::TDATA_W-1:0] in_tdata,   // col[4:0], row[9:5], value[17:10]
  input  logic [0:0]                  in_tuser,   // req_type[0]
  input  logic                        q_pop,
  output logic                        q_valid,
  output awb_pkg::item_t              q_item
);

  localparam int QW = $clog2(awb_pkg::QUEUE_DEPTH);
  localparam logic [6:0] SIDE_LIM = 7'(MAX_SIDE);
  localparam logic [QW:0] FULL_CNT = (QW + 1)'(awb_pkg::QUEUE_DEPTH);

  awb_pkg::item_t mem_r [awb_pkg::QUEUE_DEPTH];
  logic [QW-1:0]  wr_ptr_r;
  logic [QW-1:0]  rd_ptr_r;
  logic [QW:0]    count_r;
  logic [QW:0]    count_nxt;

  awb_pkg::item_t item_in;
  logic           fits;
  logic           push;
  logic           pop;

  always_comb begin
    item_in.op    = awb_pkg::op_t'(in_tuser[0]);
    item_in.col   = in_tdata[4:0];
    item_in.row   = in_tdata[9:5];
    item_in.value = in_tdata[17:10];
  end

  // writes outside the stored image are taken and dropped here
  assign fits = ({2'b00, item_in.col} < SIDE_LIM) && ({2'b00, item_in.row} < SIDE_LIM);

  assign in_tready = (count_r != FULL_CNT);
  assign push      = in_tvalid && in_tready && ((item_in.op == awb_pkg::OP_SAMPLE) || fits);
  assign q_valid   = (count_r != '0);
  assign pop       = q_pop && q_valid;
  assign q_item    = mem_r[rd_ptr_r];
  assign count_nxt = count_r + (QW + 1)'(push) - (QW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= item_in;
  end

endmodule

### rtl/awb_bank_ram.sv
module awb_bank_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/awb_back.sv
module awb_back #(
  parameter int MAX_SIDE = awb_pkg::DEF_MAX_SIDE
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  awb_pkg::cfg_t               cfg,
  input  logic                        q_valid,
  input  awb_pkg::item_t              q_item,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [awb_pkg::TDATA_W-1:0] out_tdata   // warped[7:0], col[12:8], row[17:13]
);

  localparam int HALF       = (MAX_SIDE + 1) / 2;
  localparam int BANK_DEPTH = HALF * HALF;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int NSTG       = 9;
  localparam logic [12:0] ONE13 = 13'd4096;

  // six restoring-division steps: returns {remainder, quotient bits}
  function automatic logic [11:0] div_step6(input logic [5:0] rem_in,
                                            input logic [5:0] bits,
                                            input logic [5:0] divisor);
    logic [6:0] r;
    logic [5:0] rem;
    logic [5:0] q;
    rem = rem_in;
    q   = '0;
    for (int i = 5; i >= 0; i--) begin
      r = {rem, bits[i]};
      if (r >= {1'b0, divisor}) begin
        q[i] = 1'b1;
        r    = r - {1'b0, divisor};
      end
      rem = r[5:0];
    end
    return {rem, q};
  endfunction

  logic           adv;
  logic           out_valid_r;
  logic [awb_pkg::TDATA_W-1:0] out_data_r;
  logic [NSTG-1:0] vld_r;
  awb_pkg::item_t  it_r [NSTG];

  // whole back end moves together; stalls only when the output word is held
  assign adv   = !out_valid_r || out_tready;
  assign q_pop = q_valid && adv;

  // stages 0..2: normalized centre, (2c+1)*4096/side in three 6-bit slices
  logic [11:0] dx0, dy0, dx1, dy1, dx2, dy2;
  logic [5:0]  qx_hi_r, qy_hi_r, rx0_r, ry0_r, rx1_r, ry1_r;
  logic [11:0] qx_hm_r, qy_hm_r;
  logic signed [17:0] x_r, y_r, x_nxt, y_nxt;

  always_comb begin
    dx0   = div_step6(6'd0, {q_item.col, 1'b1}, cfg.side);
    dy0   = div_step6(6'd0, {q_item.row, 1'b1}, cfg.side);
    dx1   = div_step6(rx0_r, 6'd0, cfg.side);
    dy1   = div_step6(ry0_r, 6'd0, cfg.side);
    dx2   = div_step6(rx1_r, 6'd0, cfg.side);
    dy2   = div_step6(ry1_r, 6'd0, cfg.side);
    x_nxt = $signed({qx_hm_r, dx2[5:0]}) - 18'sd4096;
    y_nxt = $signed({qy_hm_r, dy2[5:0]}) - 18'sd4096;
  end

  // stage 3: matrix products, stage 4: row sums, stage 5: floor and shift
  logic signed [33:0] pxx_r, pxy_r, pyx_r, pyy_r;
  logic signed [33:0] pxx_nxt, pxy_nxt, pyx_nxt, pyy_nxt;
  logic signed [34:0] sx_r, sy_r, sx_nxt, sy_nxt;
  logic signed [23:0] xm_r, ym_r, xm_nxt, ym_nxt;

  always_comb begin
    pxx_nxt = 34'($signed(cfg.coef_xx)) * 34'(x_r);
    pxy_nxt = 34'($signed(cfg.coef_xy)) * 34'(y_r);
    pyx_nxt = 34'($signed(cfg.coef_yx)) * 34'(x_r);
    pyy_nxt = 34'($signed(cfg.coef_yy)) * 34'(y_r);
    sx_nxt  = 35'(pxx_r) + 35'(pxy_r);
    sy_nxt  = 35'(pyx_r) + 35'(pyy_r);
    xm_nxt  = 24'(sx_r >>> 12) + 24'($signed(cfg.shift_x));
    ym_nxt  = 24'(sy_r >>> 12) + 24'($signed(cfg.shift_y));
  end

  // stage 6: range check and source position in Q.13, biased by one tap
  logic        in6_r, in6_nxt;
  logic [13:0] tx, ty;
  logic [18:0] ux_r, uy_r, ux_nxt, uy_nxt;

  always_comb begin
    in6_nxt = (xm_r >= -24'sd4096) && (xm_r <= 24'sd4096) &&
              (ym_r >= -24'sd4096) && (ym_r <= 24'sd4096);
    tx      = 14'(xm_r + 24'sd4096);
    ty      = 14'(ym_r + 24'sd4096);
    ux_nxt  = 19'(tx) * 19'(cfg.side) + 19'd4096;
    uy_nxt  = 19'(ty) * 19'(cfg.side) + 19'd4096;
  end

  // stage 7: bank reads; cb is base tap + 1, taps sit at cb-1 and cb
  logic [5:0]  cbx, cby;
  logic        xlo_ok_r, xhi_ok_r, ylo_ok_r, yhi_ok_r;
  logic        xlo_ok_nxt, xhi_ok_nxt, ylo_ok_nxt, yhi_ok_nxt;
  logic        cbx0_r, cby0_r;
  logic [11:0] fx_r, fy7_r;
  logic        in7_r;
  logic [BANK_AW-1:0] wr_addr;
  logic [7:0]  rd_data [4];

  always_comb begin
    cbx        = ux_r[18:13];
    cby        = uy_r[18:13];
    xlo_ok_nxt = (cbx != 6'd0) && (cbx <= cfg.side);
    xhi_ok_nxt = (cbx < cfg.side);
    ylo_ok_nxt = (cby != 6'd0) && (cby <= cfg.side);
    yhi_ok_nxt = (cby < cfg.side);
    wr_addr    = BANK_AW'(int'(it_r[6].row[4:1]) * HALF + int'(it_r[6].col[4:1]));
  end

  // bank {row parity, col parity}; the four taps always land in distinct banks
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic PC = 1'(b % 2);
    localparam logic PR = 1'(b / 2);
    logic [4:0]         colh;
    logic [4:0]         rowh;
    logic [BANK_AW-1:0] raddr;
    logic               we;

    always_comb begin
      colh  = (PC && !cbx[0]) ? cbx[5:1] - 5'd1 : cbx[5:1];
      rowh  = (PR && !cby[0]) ? cby[5:1] - 5'd1 : cby[5:1];
      raddr = BANK_AW'(int'(rowh) * HALF + int'(colh));
      we    = adv && vld_r[6] && (it_r[6].op == awb_pkg::OP_WRITE) &&
              (it_r[6].col[0] == PC) && (it_r[6].row[0] == PR);
    end

    awb_bank_ram #(
      .DEPTH (BANK_DEPTH),
      .AW    (BANK_AW)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (wr_addr),
      .wdata (it_r[6].value),
      .re    (adv),
      .raddr (raddr),
      .rdata (rd_data[b])
    );
  end

  // stage 8: zero taps outside the image, blend along x
  logic [7:0]  t00, t10, t01, t11;
  logic [12:0] wx0;
  logic [20:0] r0_r, r1_r, r0_nxt, r1_nxt;
  logic [11:0] fy8_r;
  logic        in8_r;

  always_comb begin
    t00    = (xlo_ok_r && ylo_ok_r) ? rd_data[{!cby0_r, !cbx0_r}] : 8'd0;
    t10    = (xhi_ok_r && ylo_ok_r) ? rd_data[{!cby0_r,  cbx0_r}] : 8'd0;
    t01    = (xlo_ok_r && yhi_ok_r) ? rd_data[{ cby0_r, !cbx0_r}] : 8'd0;
    t11    = (xhi_ok_r && yhi_ok_r) ? rd_data[{ cby0_r,  cbx0_r}] : 8'd0;
    wx0    = ONE13 - 13'(fx_r);
    r0_nxt = 21'(t00) * 21'(wx0) + 21'(t10) * 21'(fx_r);
    r1_nxt = 21'(t01) * 21'(wx0) + 21'(t11) * 21'(fx_r);
  end

  // output: blend along y, drop 24 fraction bits, clamp
  logic [12:0] wy0;
  logic [33:0] acc;
  logic [7:0]  blend;
  logic [7:0]  warped_nxt;

  always_comb begin
    wy0        = ONE13 - 13'(fy8_r);
    acc        = 34'(r0_r) * 34'(wy0) + 34'(r1_r) * 34'(fy8_r);
    blend      = (acc[33:24] > 10'd255) ? 8'd255 : acc[31:24];
    warped_nxt = in8_r ? blend : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NSTG-2:0], q_valid};
      out_valid_r <= vld_r[NSTG-1] && (it_r[NSTG-1].op == awb_pkg::OP_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it_r[0] <= q_item;
      for (int k = 1; k < NSTG; k++) it_r[k] <= it_r[k-1];
      qx_hi_r  <= dx0[5:0];
      rx0_r    <= dx0[11:6];
      qy_hi_r  <= dy0[5:0];
      ry0_r    <= dy0[11:6];
      qx_hm_r  <= {qx_hi_r, dx1[5:0]};
      rx1_r    <= dx1[11:6];
      qy_hm_r  <= {qy_hi_r, dy1[5:0]};
      ry1_r    <= dy1[11:6];
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      pxx_r    <= pxx_nxt;
      pxy_r    <= pxy_nxt;
      pyx_r    <= pyx_nxt;
      pyy_r    <= pyy_nxt;
      sx_r     <= sx_nxt;
      sy_r     <= sy_nxt;
      xm_r     <= xm_nxt;
      ym_r     <= ym_nxt;
      in6_r    <= in6_nxt;
      ux_r     <= ux_nxt;
      uy_r     <= uy_nxt;
      xlo_ok_r <= xlo_ok_nxt;
      xhi_ok_r <= xhi_ok_nxt;
      ylo_ok_r <= ylo_ok_nxt;
      yhi_ok_r <= yhi_ok_nxt;
      cbx0_r   <= cbx[0];
      cby0_r   <= cby[0];
      fx_r     <= ux_r[12:1];
      fy7_r    <= uy_r[12:1];
      in7_r    <= in6_r;
      r0_r     <= r0_nxt;
      r1_r     <= r1_nxt;
      fy8_r    <= fy7_r;
      in8_r    <= in7_r;
      out_data_r <= {{(awb_pkg::TDATA_W - 18){1'b0}},
                     it_r[NSTG-1].row, it_r[NSTG-1].col, warped_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/affine_warp_bilinear_sampler.sv
// A sample word passes through the queue, three division slices, map, sum, shift, position,
// bank read, x blend and y blend to the output register that drives out_tvalid.
// Throughput: one word per cycle while not stalled, set by one read port on each of four banks.
// Pixel writes that are queued take the same pipeline slots and produce no output word.
// Reset (rst_n low, synchronous) empties queue and pipeline and restores register defaults;
// the image store is not cleared, a pixel reads as unknown until written.
module affine_warp_bilinear_sampler #(
  parameter int MAX_SIDE = awb_pkg::DEF_MAX_SIDE
) (
  input  logic                        clk,
  input  logic                        rst_n,

  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [awb_pkg::TDATA_W-1:0] in_tdata,    // pixel_col[4:0], pixel_row[9:5],
                                                   // pixel_value[17:10], zero pad
  input  logic [0:0]                  in_tuser,    // req_type[0]: 0 write, 1 sample

  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [awb_pkg::TDATA_W-1:0] out_tdata,   // warped_value[7:0], result_col[12:8],
                                                   // result_row[17:13], zero pad

  // register port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [awb_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [awb_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [awb_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  // register map, one 32-bit slot per register
  typedef enum logic [2:0] {
    REG_IMAGE_SIDE = 3'd0,
    REG_COEF_XX    = 3'd1,
    REG_COEF_XY    = 3'd2,
    REG_COEF_YX    = 3'd3,
    REG_COEF_YY    = 3'd4,
    REG_SHIFT_X    = 3'd5,
    REG_SHIFT_Y    = 3'd6
  } reg_idx_t;

  localparam logic [6:0] SIDE_LIM = 7'(MAX_SIDE);

  logic [5:0]         side_r;
  logic signed [15:0] coef_xx_r, coef_xy_r, coef_yx_r, coef_yy_r;
  logic signed [15:0] shift_x_r, shift_y_r;

  logic          cfg_we;
  reg_idx_t      reg_sel;
  logic [5:0]    side_eff;
  awb_pkg::cfg_t cfg;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r    <= 6'd28;
      coef_xx_r <= 16'sd4096;
      coef_xy_r <= 16'sd0;
      coef_yx_r <= 16'sd0;
      coef_yy_r <= 16'sd4096;
      shift_x_r <= 16'sd0;
      shift_y_r <= 16'sd0;
    end else if (cfg_we) begin
      case (reg_sel)
        REG_IMAGE_SIDE: side_r    <= cfg_pwdata[5:0];
        REG_COEF_XX:    coef_xx_r <= $signed(cfg_pwdata[15:0]);
        REG_COEF_XY:    coef_xy_r <= $signed(cfg_pwdata[15:0]);
        REG_COEF_YX:    coef_yx_r <= $signed(cfg_pwdata[15:0]);
        REG_COEF_YY:    coef_yy_r <= $signed(cfg_pwdata[15:0]);
        REG_SHIFT_X:    shift_x_r <= $signed(cfg_pwdata[15:0]);
        REG_SHIFT_Y:    shift_y_r <= $signed(cfg_pwdata[15:0]);
        default: ;  // unmapped slot, write dropped
      endcase
    end
  end

  // readback: side zero-extended, Q4.12 values sign-extended
  always_comb begin
    case (reg_sel)
      REG_IMAGE_SIDE: cfg_prdata = {26'd0, side_r};
      REG_COEF_XX:    cfg_prdata = 32'(coef_xx_r);
      REG_COEF_XY:    cfg_prdata = 32'(coef_xy_r);
      REG_COEF_YX:    cfg_prdata = 32'(coef_yx_r);
      REG_COEF_YY:    cfg_prdata = 32'(coef_yy_r);
      REG_SHIFT_X:    cfg_prdata = 32'(shift_x_r);
      REG_SHIFT_Y:    cfg_prdata = 32'(shift_y_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // programmed side saturates into 2..MAX_SIDE
  always_comb begin
    if (side_r < 6'd2) begin
      side_eff = 6'd2;
    end else if ({1'b0, side_r} > SIDE_LIM) begin
      side_eff = 6'(MAX_SIDE);
    end else begin
      side_eff = side_r;
    end
    cfg.side    = side_eff;
    cfg.coef_xx = coef_xx_r;
    cfg.coef_xy = coef_xy_r;
    cfg.coef_yx = coef_yx_r;
    cfg.coef_yy = coef_yy_r;
    cfg.shift_x = shift_x_r;
    cfg.shift_y = shift_y_r;
  end

  // front: take words, drop out-of-store writes, queue the rest
  logic           q_valid;
  logic           q_pop;
  awb_pkg::item_t q_item;

  awb_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_pop     (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // back: map, banked image store, bilinear blend, output register
  awb_back #(
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
